@@ rtl/atan_pkg.sv @@
// Shared types and constants for the four-quadrant arctangent pipeline.
package atan_pkg;

  localparam int COORD_WIDTH_DEF     = 16;
  localparam int ANGLE_FRAC_BITS_DEF = 13;
  localparam int ANGLE_WIDTH         = 16;
  localparam int RATIO_WIDTH         = 16;
  localparam int INNER_FRAC          = 18;
  localparam int ACC_WIDTH           = 22;
  localparam int NUM_COEF            = 7;
  localparam int HORNER_STEPS        = NUM_COEF - 1;

  localparam logic signed [ACC_WIDTH-1:0] HALF_PI_Q18 = 22'sd411775;
  localparam logic signed [ACC_WIDTH-1:0] PI_Q18      = 22'sd823550;

  // Minimax coefficients in Q.18, highest power first
  function automatic logic signed [ACC_WIDTH-1:0] poly_coef(input logic [2:0] idx);
    logic signed [ACC_WIDTH-1:0] c;
    unique case (idx)
      3'd0:    c = 22'sd1891;
      3'd1:    c = -22'sd9191;
      3'd2:    c = 22'sd21411;
      3'd3:    c = -22'sd35061;
      3'd4:    c = 22'sd52053;
      3'd5:    c = -22'sd87359;
      3'd6:    c = 22'sd262144;
      default: c = '0;
    endcase
    return c;
  endfunction

  // Octant and sign flags that travel beside the data
  typedef struct packed {
    logic yneg;
    logic xneg;
    logic ybig;
    logic zero;
  } oct_flags_t;

endpackage

@@ rtl/atan_div.sv @@
// Pipelined restoring divider: ratio = floor(lo * 2^16 / hi), one quotient bit per stage.
module atan_div #(
  parameter int COORD_WIDTH = atan_pkg::COORD_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic [COORD_WIDTH-1:0]           lo,
  input  logic [COORD_WIDTH-1:0]           hi,
  input  atan_pkg::oct_flags_t             in_flags,
  output logic                             out_valid,
  output logic [atan_pkg::RATIO_WIDTH-1:0] ratio,
  output atan_pkg::oct_flags_t             out_flags
);
  import atan_pkg::*;

  localparam int NST = RATIO_WIDTH;
  localparam int RW  = COORD_WIDTH + 1;

  logic [RW-1:0]          rem   [NST+1];
  logic [COORD_WIDTH-1:0] dvsr  [NST+1];
  logic [RATIO_WIDTH-1:0] quo   [NST+1];
  oct_flags_t             flg   [NST+1];
  logic                   vld   [NST+1];

  // Stage zero: lo < hi, or lo == hi which saturates
  always_comb begin
    rem[0]  = {1'b0, lo};
    dvsr[0] = hi;
    quo[0]  = '0;
    flg[0]  = in_flags;
    vld[0]  = in_valid;
  end

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [RW:0]   shl;
    logic [RW:0]   dif;
    logic          ge;
    always_comb begin
      shl = {rem[s], 1'b0};
      dif = shl - {2'b00, dvsr[s]};
      ge  = !dif[RW];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
      if (adv) begin
        rem[s+1]  <= ge ? dif[RW-1:0] : shl[RW-1:0];
        dvsr[s+1] <= dvsr[s];
        quo[s+1]  <= {quo[s][RATIO_WIDTH-2:0], ge};
        flg[s+1]  <= flg[s];
      end
    end
  end

  // Saturate the equal-magnitude case to all ones
  always_comb begin
    out_valid = vld[NST];
    out_flags = flg[NST];
    ratio     = (rem[NST] >= {1'b0, dvsr[NST]}) ? '1 : quo[NST];
  end

endmodule

@@ rtl/atan_poly.sv @@
// Horner evaluation of the odd arctangent polynomial, one product per stage.
module atan_poly (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             adv,
  input  logic                             in_valid,
  input  logic [atan_pkg::RATIO_WIDTH-1:0] ratio,
  input  atan_pkg::oct_flags_t             in_flags,
  output logic                             out_valid,
  output logic signed [atan_pkg::ACC_WIDTH-1:0] atan_q18,
  output atan_pkg::oct_flags_t             out_flags
);
  import atan_pkg::*;

  localparam int NST = HORNER_STEPS + 2;

  logic [RATIO_WIDTH-1:0]      r   [NST+1];
  logic [RATIO_WIDTH+2:0]      r2  [NST+1];
  logic signed [ACC_WIDTH-1:0] acc [NST+1];
  oct_flags_t                  flg [NST+1];
  logic                        vld [NST+1];

  always_comb begin
    r[0]   = ratio;
    r2[0]  = '0;
    acc[0] = '0;
    flg[0] = in_flags;
    vld[0] = in_valid;
  end

  for (genvar s = 0; s < NST; s++) begin : g_stage
    logic [2*RATIO_WIDTH-1:0]          sq;
    logic signed [ACC_WIDTH+RATIO_WIDTH+3:0] prod;
    logic signed [ACC_WIDTH+RATIO_WIDTH+3:0] rnd;
    logic signed [ACC_WIDTH-1:0]       nacc;
    logic [RATIO_WIDTH+2:0]            nr2;
    always_comb begin
      sq   = '0;
      prod = '0;
      rnd  = '0;
      nr2  = r2[s];
      if (s == 0) begin
        // Square the ratio into Q0.18 and load the top coefficient
        sq   = r[s] * r[s];
        nr2  = (RATIO_WIDTH+3)'((sq + 32'd8192) >> 14);
        nacc = poly_coef(3'd0);
      end else if (s <= HORNER_STEPS) begin
        prod = acc[s] * $signed({1'b0, r2[s]});
        rnd  = (prod + 131072) >>> 18;
        nacc = ACC_WIDTH'(rnd) + poly_coef(3'(s));
      end else begin
        prod = acc[s] * $signed({4'b0, r[s]});
        rnd  = (prod + 32768) >>> 16;
        nacc = ACC_WIDTH'(rnd);
      end
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        vld[s+1] <= 1'b0;
      end else if (adv) begin
        vld[s+1] <= vld[s];
      end
      if (adv) begin
        r[s+1]   <= r[s];
        r2[s+1]  <= nr2;
        acc[s+1] <= nacc;
        flg[s+1] <= flg[s];
      end
    end
  end

  always_comb begin
    out_valid = vld[NST];
    atan_q18  = acc[NST];
    out_flags = flg[NST];
  end

endmodule

@@ rtl/atan2_polynomial_approx_top.sv @@
// Top level of the pipelined four-quadrant arctangent.
//
//   channel  signals                           role
//   in       in_valid, in_stall, coord_y/x     coordinate pair transfer
//   out      out_valid, out_stall, angle       angle transfer
//
// One pair is taken every cycle while in_stall is low; the pipeline is the front stage,
// 16 divider stages, 8 polynomial stages, the octant stage and the output register.
// The whole pipeline advances as one unit; out_stall with out_valid high freezes every stage.
// in_stall is high only while the output register is full and stalled.
// Reset clears the valid bits only.
module atan2_polynomial_approx_top #(
  parameter int COORD_WIDTH     = atan_pkg::COORD_WIDTH_DEF,
  parameter int ANGLE_FRAC_BITS = atan_pkg::ANGLE_FRAC_BITS_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     in_valid,
  output logic                                     in_stall,
  input  logic signed [COORD_WIDTH-1:0]            coord_y,
  input  logic signed [COORD_WIDTH-1:0]            coord_x,
  output logic                                     out_valid,
  input  logic                                     out_stall,
  output logic signed [atan_pkg::ANGLE_WIDTH-1:0]  angle
);
  import atan_pkg::*;

  logic adv;
  assign adv      = !(out_valid && out_stall);
  assign in_stall = !adv;

  // Front stage: magnitudes and octant
  logic [COORD_WIDTH-1:0] ay, ax, lo, hi;
  oct_flags_t             fflags;
  logic                   f_valid;
  oct_flags_t             f_flags;
  logic [COORD_WIDTH-1:0] f_lo, f_hi;

  always_comb begin
    ay            = coord_y[COORD_WIDTH-1] ? COORD_WIDTH'(-coord_y) : coord_y;
    ax            = coord_x[COORD_WIDTH-1] ? COORD_WIDTH'(-coord_x) : coord_x;
    fflags.yneg   = coord_y[COORD_WIDTH-1];
    fflags.xneg   = coord_x[COORD_WIDTH-1];
    fflags.ybig   = ay > ax;
    hi            = fflags.ybig ? ay : ax;
    lo            = fflags.ybig ? ax : ay;
    fflags.zero   = (hi == '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= in_valid;
    end
    if (adv) begin
      f_flags <= fflags;
      f_lo    <= lo;
      f_hi    <= fflags.zero ? COORD_WIDTH'(1) : hi;
    end
  end

  logic                   d_valid;
  logic [RATIO_WIDTH-1:0] d_ratio;
  oct_flags_t             d_flags;

  atan_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(f_valid), .lo(f_lo), .hi(f_hi), .in_flags(f_flags),
    .out_valid(d_valid), .ratio(d_ratio), .out_flags(d_flags)
  );

  logic                        p_valid;
  logic signed [ACC_WIDTH-1:0] p_atan;
  oct_flags_t                  p_flags;

  atan_poly u_poly (
    .clk(clk), .rst(rst), .adv(adv),
    .in_valid(d_valid), .ratio(d_ratio), .in_flags(d_flags),
    .out_valid(p_valid), .atan_q18(p_atan), .out_flags(p_flags)
  );

  // Octant stage: reflect about pi/4 and pi/2, clamp at zero
  logic signed [ACC_WIDTH-1:0] t1, t2, t3;
  logic                        o_valid;
  logic [ACC_WIDTH-1:0]        o_t;
  oct_flags_t                  o_flags;

  always_comb begin
    t1 = p_flags.ybig ? HALF_PI_Q18 - p_atan : p_atan;
    t2 = p_flags.xneg ? PI_Q18 - t1 : t1;
    t3 = (t2 < 0) ? '0 : t2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (adv) begin
      o_valid <= p_valid;
    end
    if (adv) begin
      o_t     <= ACC_WIDTH'(t3);
      o_flags <= p_flags;
    end
  end

  // Output stage: round to the angle format, saturate, apply sign; a zero input gives zero
  localparam int SHR = (ANGLE_FRAC_BITS < INNER_FRAC) ? INNER_FRAC - ANGLE_FRAC_BITS : 0;
  localparam int SHL = (ANGLE_FRAC_BITS > INNER_FRAC) ? ANGLE_FRAC_BITS - INNER_FRAC : 0;
  localparam int MW  = ACC_WIDTH + SHL + 1;

  logic [MW-1:0]          mag;
  logic [ANGLE_WIDTH-1:0] mag_sat;
  logic [ANGLE_WIDTH-1:0] res;

  always_comb begin
    if (SHR > 0) begin
      mag = (MW'(o_t) + (MW'(1) << (SHR - 1))) >> SHR;
    end else begin
      mag = MW'(o_t) << SHL;
    end
    mag_sat = (mag > MW'(32767)) ? ANGLE_WIDTH'(32767) : mag[ANGLE_WIDTH-1:0];
    if (o_flags.zero) begin
      res = '0;
    end else begin
      res = o_flags.yneg ? ANGLE_WIDTH'(-mag_sat) : mag_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= o_valid;
    end
    if (adv) begin
      angle <= res;
    end
  end

`ifndef SYNTHESIS
  // A stalled result is not replaced
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(angle))
    else $error("angle changed under stall");

  // Input stall only mirrors a blocked output
  a_stall: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // Angle magnitude stays within pi (checked with 13 fraction bits)
  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && ANGLE_FRAC_BITS == 13 |-> angle <= 16'sd25736 && angle >= -16'sd25736)
    else $error("angle out of range");
`endif

endmodule
